// File: rtl/icache_pkg.sv
// Package for the inode cache table: slot count, status codes, request types.
// No dependencies; used by every module of the block.
`default_nettype none
package icache_pkg;
   localparam int TABLE_SLOTS = 32;
   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] MODE_GET = 2'd0;
   localparam logic [1:0] MODE_PUT = 2'd1;
   localparam logic [1:0] MODE_MARK = 2'd2;

   localparam logic [2:0] ST_HIT = 3'd0;
   localparam logic [2:0] ST_LOADED = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_RELEASED = 3'd3;
   localparam logic [2:0] ST_FREED = 3'd4;
   localparam logic [2:0] ST_ERROR = 3'd5;
   localparam logic [2:0] ST_MARKED = 3'd6;

   typedef enum logic [1:0] {
      OP_GET = 2'd0,
      OP_PUT = 2'd1,
      OP_MARK = 2'd2,
      OP_ERROR = 2'd3
   } op_type;

   typedef struct packed {
      op_type op;
      logic [15:0] number;
      logic [15:0] device;
      logic [4:0] slot_index;
      logic links_zero;
   } cmd_type;
endpackage
`default_nettype wire

// File: rtl/icache_front.sv
// Front part: accepts requests, classifies them and queues commands.
// Depends on icache_pkg.
`default_nettype none
module icache_front
   import icache_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [1:0] req_mode,
   input wire logic [15:0] req_inode_number,
   input wire logic [15:0] req_device,
   input wire logic [4:0] req_slot_index,
   input wire logic req_links_zero,
   output logic cmd_valid,
   input wire logic cmd_ready,
   output cmd_type cmd
);
   localparam int PW = $clog2(QUEUE_DEPTH);
   cmd_type queue_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PW:0] count_ff;
   cmd_type cmd_in;
   logic push, pop;

   always_comb begin
      cmd_in.number = req_inode_number;
      cmd_in.device = req_device;
      cmd_in.slot_index = req_slot_index;
      cmd_in.links_zero = req_links_zero;
      case (req_mode)
         MODE_GET: cmd_in.op = OP_GET;
         MODE_PUT: cmd_in.op = OP_PUT;
         MODE_MARK: cmd_in.op = OP_MARK;
         default: cmd_in.op = OP_ERROR;
      endcase
   end

   assign req_ready = count_ff != (PW+1)'(QUEUE_DEPTH);
   assign push = req_valid && req_ready;
   assign cmd_valid = count_ff != '0;
   assign pop = cmd_valid && cmd_ready;
   assign cmd = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PW+1)'(QUEUE_DEPTH)) else $error("queue overfill");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      count_ff == (PW+1)'(QUEUE_DEPTH) |-> !push) else $error("push when full");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff)) else $error("pointer skew");
endmodule
`default_nettype wire

// File: rtl/icache_back.sv
// Back part: slot table, lookup, victim scan, put and mark handling, result register.
// Depends on icache_pkg.
`default_nettype none
module icache_back
   import icache_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic cmd_valid,
   output logic cmd_ready,
   input cmd_type cmd,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [2:0] rsp_status,
   output logic [4:0] rsp_slot,
   output logic rsp_writeback_valid,
   output logic [15:0] rsp_writeback_number,
   output logic [15:0] rsp_writeback_device,
   output logic rsp_read_valid,
   output logic [15:0] rsp_read_number,
   output logic [15:0] rsp_read_device,
   output logic rsp_free_valid,
   output logic [15:0] rsp_free_number
);
   typedef enum logic [1:0] {S_IDLE, S_LOOKUP, S_SCAN, S_RESP} state_type;
   localparam int CW = $clog2(TABLE_SLOTS + 1);

   state_type state_ff;
   cmd_type cmd_ff;
   logic [15:0] num_ff [TABLE_SLOTS];
   logic [15:0] dev_ff [TABLE_SLOTS];
   logic [7:0] ref_ff [TABLE_SLOTS];
   logic dirty_ff [TABLE_SLOTS];
   logic [SLOT_W-1:0] victim_ff;
   logic [CW-1:0] scanned_ff;
   logic hit_ff;
   logic [SLOT_W-1:0] hit_slot_ff;

   logic [2:0] status_ff;
   logic [4:0] slot_ff;
   logic wb_v_ff, rd_v_ff, fr_v_ff;
   logic [15:0] wb_num_ff, wb_dev_ff, rd_num_ff, rd_dev_ff, fr_num_ff;

   logic hit_in;
   logic [SLOT_W-1:0] hit_slot_in;
   logic [SLOT_W-1:0] victim_nx;
   logic in_range;
   logic [SLOT_W-1:0] sidx;

   always_comb begin
      hit_in = 1'b0;
      hit_slot_in = '0;
      for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
         if (num_ff[i] == cmd_ff.number && dev_ff[i] == cmd_ff.device) begin
            hit_in = 1'b1;
            hit_slot_in = SLOT_W'(i);
         end
      end
   end

   assign victim_nx = (victim_ff == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : victim_ff + 1'b1;
   assign in_range = {27'd0, cmd_ff.slot_index} < 32'(TABLE_SLOTS);
   assign sidx = SLOT_W'(cmd_ff.slot_index);
   assign cmd_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_RESP;
   assign rsp_status = status_ff;
   assign rsp_slot = slot_ff;
   assign rsp_writeback_valid = wb_v_ff;
   assign rsp_writeback_number = wb_num_ff;
   assign rsp_writeback_device = wb_dev_ff;
   assign rsp_read_valid = rd_v_ff;
   assign rsp_read_number = rd_num_ff;
   assign rsp_read_device = rd_dev_ff;
   assign rsp_free_valid = fr_v_ff;
   assign rsp_free_number = fr_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         victim_ff <= '0;
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            num_ff[i] <= '0;
            dev_ff[i] <= '0;
            ref_ff[i] <= '0;
            dirty_ff[i] <= 1'b0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff <= cmd;
                  state_ff <= S_LOOKUP;
               end
            end
            S_LOOKUP: begin
               status_ff <= ST_ERROR;
               slot_ff <= cmd_ff.slot_index;
               wb_v_ff <= 1'b0;
               wb_num_ff <= '0;
               wb_dev_ff <= '0;
               rd_v_ff <= 1'b0;
               rd_num_ff <= '0;
               rd_dev_ff <= '0;
               fr_v_ff <= 1'b0;
               fr_num_ff <= '0;
               hit_ff <= hit_in;
               hit_slot_ff <= hit_slot_in;
               scanned_ff <= '0;
               state_ff <= S_RESP;
               case (cmd_ff.op)
                  OP_GET: begin
                     state_ff <= S_SCAN;
                  end
                  OP_PUT: begin
                     if (in_range && ref_ff[sidx] != 8'd0) begin
                        if (ref_ff[sidx] > 8'd1) begin
                           ref_ff[sidx] <= ref_ff[sidx] - 8'd1;
                           status_ff <= ST_RELEASED;
                        end else if (cmd_ff.links_zero) begin
                           status_ff <= ST_FREED;
                           fr_v_ff <= 1'b1;
                           fr_num_ff <= num_ff[sidx];
                           num_ff[sidx] <= '0;
                           dev_ff[sidx] <= '0;
                           ref_ff[sidx] <= '0;
                           dirty_ff[sidx] <= 1'b0;
                        end else begin
                           status_ff <= ST_RELEASED;
                           ref_ff[sidx] <= '0;
                           if (dirty_ff[sidx]) begin
                              wb_v_ff <= 1'b1;
                              wb_num_ff <= num_ff[sidx];
                              wb_dev_ff <= dev_ff[sidx];
                              dirty_ff[sidx] <= 1'b0;
                           end
                        end
                     end
                  end
                  OP_MARK: begin
                     if (in_range) begin
                        dirty_ff[sidx] <= 1'b1;
                        status_ff <= ST_MARKED;
                     end
                  end
                  default: begin
                     slot_ff <= '0;
                  end
               endcase
            end
            S_SCAN: begin
               if (hit_ff) begin
                  if (ref_ff[hit_slot_ff] != 8'hff)
                     ref_ff[hit_slot_ff] <= ref_ff[hit_slot_ff] + 8'd1;
                  status_ff <= ST_HIT;
                  slot_ff <= 5'(hit_slot_ff);
                  state_ff <= S_RESP;
               end else if (scanned_ff == CW'(TABLE_SLOTS)) begin
                  status_ff <= ST_FULL;
                  slot_ff <= '0;
                  state_ff <= S_RESP;
               end else begin
                  victim_ff <= victim_nx;
                  scanned_ff <= scanned_ff + 1'b1;
                  if (ref_ff[victim_ff] == 8'd0) begin
                     status_ff <= ST_LOADED;
                     slot_ff <= 5'(victim_ff);
                     if (dirty_ff[victim_ff]) begin
                        wb_v_ff <= 1'b1;
                        wb_num_ff <= num_ff[victim_ff];
                        wb_dev_ff <= dev_ff[victim_ff];
                     end
                     num_ff[victim_ff] <= cmd_ff.number;
                     dev_ff[victim_ff] <= cmd_ff.device;
                     ref_ff[victim_ff] <= 8'd1;
                     dirty_ff[victim_ff] <= 1'b0;
                     rd_v_ff <= 1'b1;
                     rd_num_ff <= cmd_ff.number;
                     rd_dev_ff <= cmd_ff.device;
                     state_ff <= S_RESP;
                  end
               end
            end
            S_RESP: begin
               if (rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> scanned_ff <= CW'(TABLE_SLOTS)) else $error("scan overrun");
   a_loaded_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_LOADED |-> rsp_read_valid) else $error("load w/o read");
   a_free_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_FREED |-> !rsp_free_valid) else $error("stray free");
endmodule
`default_nettype wire

// File: rtl/inode_cache_table_top.sv
// Inode cache table top: request queue front and table back part.
// A request passes the front queue, then the back part's IDLE, LOOKUP and RESP states;
// a get also passes SCAN, which stops on a hit, a free victim or a fully scanned table.
// The back part takes no new command until its last response has been taken.
// Reset: synchronous, clears all slots, the victim pointer and the queue.
// Depends on icache_pkg, icache_front, icache_back.
`default_nettype none
module inode_cache_table_top
   import icache_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [1:0] req_mode,
   input wire logic [15:0] req_inode_number,
   input wire logic [15:0] req_device,
   input wire logic [4:0] req_slot_index,
   input wire logic req_links_zero,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [2:0] rsp_status,
   output logic [4:0] rsp_slot,
   output logic rsp_writeback_valid,
   output logic [15:0] rsp_writeback_number,
   output logic [15:0] rsp_writeback_device,
   output logic rsp_read_valid,
   output logic [15:0] rsp_read_number,
   output logic [15:0] rsp_read_device,
   output logic rsp_free_valid,
   output logic [15:0] rsp_free_number
);
   logic cmd_valid, cmd_ready;
   cmd_type cmd;

   icache_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_mode, .req_inode_number,
      .req_device, .req_slot_index, .req_links_zero,
      .cmd_valid, .cmd_ready, .cmd
   );

   icache_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_slot,
      .rsp_writeback_valid, .rsp_writeback_number, .rsp_writeback_device,
      .rsp_read_valid, .rsp_read_number, .rsp_read_device,
      .rsp_free_valid, .rsp_free_number
   );
endmodule
`default_nettype wire
